### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [6:0] CODE_PAD  = 7'd65;
    localparam logic [6:0] CODE_SKIP = 7'h7F;

    // Up to three decoded bytes from one character, sent in order b0, b1, b2
    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } b64d_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } b64d_qstat_t;

    // Sextet value 0..63, CODE_PAD for '=', CODE_SKIP for anything else
    function automatic logic [6:0] b64d_classify(input logic [7:0] c);
        logic [6:0] code;
        code = CODE_SKIP;
        if (c >= 8'h41 && c <= 8'h5A)
            code = 7'(c - 8'd65);
        else if (c >= 8'h61 && c <= 8'h7A)
            code = 7'(c - 8'd71);
        else if (c >= 8'h30 && c <= 8'h39)
            code = 7'(c + 8'd4);
        else if (c == 8'h2B)
            code = 7'd62;
        else if (c == 8'h2F)
            code = 7'd63;
        else if (c == 8'h3D)
            code = CODE_PAD;
        return code;
    endfunction

endpackage

### hw/rtl/base64_stream_decoder.sv
`timescale 1ns / 1ps

// Streaming Base64 decoder. One encoded character per cycle enters on the s_ side
// and is decoded in the cycle it is accepted; characters outside A-Z a-z 0-9 + /
// are skipped, '=' flushes a partial group and mutes the input until tlast, and
// tlast returns the decoder to its reset state after that character. Decoded bytes
// leave on the m_ side one per cycle while m_tready is high, tlast marking the last
// byte produced by a character. A four-entry request queue between the decoder
// and the byte serialiser absorbs output back-pressure: input stalls only when
// four requests (up to twelve bytes) are waiting.
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] symbol
    input  logic       s_tlast,    // text_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] data_byte
    output logic       m_tlast     // run_last
);

    b64d_qstat_t qstat;
    logic        push;
    logic        pop;
    b64d_job_t   push_job;
    b64d_job_t   pop_job;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .qstat    (qstat),
        .push     (push),
        .push_job (push_job)
    );

    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .qstat    (qstat)
    );

    b64d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### hw/rtl/b64d_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_front
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,   // text_end
    input  b64d_qstat_t qstat,
    output logic        push,
    output b64d_job_t   push_job
);

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pad_reg, pad_next;
    logic [6:0]  code;
    logic [23:0] full_word;
    logic        accept;
    b64d_job_t   job;

    assign s_tready  = !qstat.full;
    assign accept    = s_tvalid && s_tready;
    assign code      = b64d_classify(s_tdata);
    assign full_word = {acc_reg, code[5:0]};

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        pad_next = pad_reg;
        job      = '0;
        if (!pad_reg)
        begin
            priority if (code == CODE_PAD)
            begin
                unique case (cnt_reg)
                    2'd2:
                    begin
                        job.n  = 2'd1;
                        job.b0 = acc_reg[11:4];
                    end
                    2'd3:
                    begin
                        job.n  = 2'd2;
                        job.b0 = acc_reg[17:10];
                        job.b1 = acc_reg[9:2];
                    end
                    default:
                    begin
                        job.n = 2'd0;
                    end
                endcase
                pad_next = 1'b1;
            end
            else if (!code[6])
            begin
                if (cnt_reg == 2'd3)
                begin
                    job.n    = 2'd3;
                    job.b0   = full_word[23:16];
                    job.b1   = full_word[15:8];
                    job.b2   = full_word[7:0];
                    acc_next = '0;
                    cnt_next = 2'd0;
                end
                else
                begin
                    acc_next = {acc_reg[11:0], code[5:0]};
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            else
            begin
                job.n = 2'd0;
            end
        end
        // final character: back to reset after it is handled
        if (s_tlast)
        begin
            acc_next = '0;
            cnt_next = 2'd0;
            pad_next = 1'b0;
        end
    end

    assign push     = accept && (job.n != 2'd0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= 2'd0;
            pad_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
        end
    end

    // a closed group leaves nothing behind in the accumulator
    `ASSERT_CLK(a_acc_clear, (cnt_reg != 2'd0) || (acc_reg == '0), "stale bits at empty group")

endmodule

### hw/rtl/b64d_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_queue
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  b64d_job_t   push_job,
    input  logic        pop,
    output b64d_job_t   pop_job,
    output b64d_qstat_t qstat
);

    b64d_job_t          mem [QDEPTH];
    logic [QIDX_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign qstat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign pop_job     = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QIDX_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QIDX_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_CLK(a_no_overflow, !(push && qstat.full), "request pushed into full queue")
    `ASSERT_CLK(a_no_underflow, !(pop && qstat.empty), "pop from empty queue")

endmodule

### hw/rtl/b64d_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_back
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  b64d_qstat_t qstat,
    input  b64d_job_t   pop_job,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic        m_tlast    // run_last
);

    b64d_job_t  job_reg, job_next;
    logic       busy_reg, busy_next;
    logic [1:0] pos_reg, pos_next;
    logic       mv_reg, mv_next;
    logic [7:0] md_reg, md_next;
    logic       ml_reg, ml_next;
    logic       out_load;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       busy_ok;

    assign out_load = !mv_reg || m_tready;
    assign cur_last = (pos_reg == job_reg.n - 2'd1);
    assign pop      = !qstat.empty && (!busy_reg || (out_load && cur_last));

    always_comb
    begin
        unique case (pos_reg)
            2'd0:    cur_byte = job_reg.b0;
            2'd1:    cur_byte = job_reg.b1;
            2'd2:    cur_byte = job_reg.b2;
            default: cur_byte = job_reg.b0;
        endcase
    end

    always_comb
    begin
        job_next  = job_reg;
        busy_next = busy_reg;
        pos_next  = pos_reg;
        mv_next   = mv_reg;
        md_next   = md_reg;
        ml_next   = ml_reg;
        if (out_load)
        begin
            mv_next = busy_reg;
            if (busy_reg)
            begin
                md_next  = cur_byte;
                ml_next  = cur_last;
                pos_next = pos_reg + 2'd1;
                if (cur_last)
                    busy_next = 1'b0;
            end
        end
        // next request loads when idle, or as the last byte of the current one leaves
        if (pop)
        begin
            job_next  = pop_job;
            pos_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        md_reg  <= md_next;
        ml_reg  <= ml_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 2'd0;
            mv_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            mv_reg   <= mv_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    assign busy_ok = !busy_reg || ((job_reg.n != 2'd0) && (pos_reg < job_reg.n));

    `ASSERT_CLK(a_busy_has_bytes, busy_ok, "busy request out of range")

endmodule
